/* rtl/core/dda_lr_pkg.sv */
package dda_lr_pkg;

    localparam int COORD_W = 6;
    localparam int FRAC_W  = 16;
    localparam int ACC_W   = COORD_W + FRAC_W;
    localparam int DEN_W   = COORD_W + 1;
    localparam int ADDR_W  = 18;
    localparam int PITCH_W = 13;
    localparam int COLOR_W = 32;

    localparam logic [PITCH_W-1:0] PITCH_RESET = PITCH_W'(64);

    // divider start request
    typedef struct packed {
        logic             start;
        logic [ACC_W-1:0] dividend;
        logic [DEN_W-1:0] divisor;
    } div_req_t;

    // divider completion
    typedef struct packed {
        logic             done;
        logic [ACC_W-1:0] quotient;
    } div_rsp_t;

endpackage

/* rtl/core/dda_lr_cmd_if.sv */
interface dda_lr_cmd_if;
    import dda_lr_pkg::*;

    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] start_x;
    logic [COORD_W-1:0] start_y;
    logic [COORD_W-1:0] end_x;
    logic [COORD_W-1:0] end_y;
    logic [COLOR_W-1:0] line_color;

    modport source (
        output valid, start_x, start_y, end_x, end_y, line_color,
        input  ready
    );

    modport sink (
        input  valid, start_x, start_y, end_x, end_y, line_color,
        output ready
    );
endinterface

/* rtl/core/dda_lr_pix_if.sv */
interface dda_lr_pix_if;
    import dda_lr_pkg::*;

    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
    logic [ADDR_W-1:0]  pixel_address;
    logic [COLOR_W-1:0] pixel_color;
    logic               last_pixel;

    modport source (
        output valid, pixel_x, pixel_y, pixel_address, pixel_color, last_pixel,
        input  ready
    );

    modport sink (
        input  valid, pixel_x, pixel_y, pixel_address, pixel_color, last_pixel,
        output ready
    );
endinterface

/* rtl/core/dda_line_rasterizer.sv */
// channel | dir | beat contents
// cmd     | in  | start_x, start_y, end_x, end_y, line_color (one line)
// pix     | out | pixel_x, pixel_y, pixel_address, pixel_color, last_pixel
// cfg     | in  | cfg_write_en / cfg_write_data: row_pitch, no handshake
//
// a line is set up when taken, then runs through the bit-serial slope divider, the slope is
// latched, then one pixel per cycle while the output register is free (1 to 64 pixels)
// cmd.ready is high only while idle; the last pixel may still wait in the
// output register while the next line is taken
// pixel stepping holds whenever the output register is full and not taken
// rst_n clears the sequencer and output valid, and sets row_pitch to 64
module dda_line_rasterizer #(
    parameter int TILE_SIZE = 64
) (
    input  logic                           clk,
    input  logic                           rst_n,
    dda_lr_cmd_if.sink                     cmd,
    dda_lr_pix_if.source                   pix,
    input  logic                           cfg_write_en,
    input  logic [dda_lr_pkg::PITCH_W-1:0] cfg_write_data
);
    import dda_lr_pkg::*;

    localparam logic [COORD_W-1:0] COORD_MAX = COORD_W'(TILE_SIZE - 1);
    localparam logic [COORD_W:0]   TILE_LIM  = (COORD_W + 1)'(TILE_SIZE);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_WALK
    } state_t;

    state_t state_reg;

    // configuration
    logic [PITCH_W-1:0] row_pitch_reg;

    // per-line registers
    logic               x_major_reg;
    logic               neg_reg;
    logic [COORD_W-1:0] maj_reg;
    logic [COORD_W-1:0] maj_end_reg;
    logic [ACC_W-1:0]   acc_reg;
    logic [ACC_W-1:0]   slope_reg;
    logic [COLOR_W-1:0] color_reg;

    // output register
    logic               out_valid_reg;
    logic [COORD_W-1:0] out_x_reg;
    logic [COORD_W-1:0] out_y_reg;
    logic [ADDR_W-1:0]  out_addr_reg;
    logic [COLOR_W-1:0] out_color_reg;
    logic               out_last_reg;

    // divider request
    logic             div_start_reg;
    logic [ACC_W-1:0] div_dividend_reg;
    logic [DEN_W-1:0] div_divisor_reg;
    div_req_t         div_req;
    div_rsp_t         div_rsp;

    // setup path
    logic [COORD_W-1:0] cx1, cy1, cx2, cy2;
    logic [COORD_W-1:0] adx, ady;
    logic               x_major;
    logic [COORD_W-1:0] maj_a, maj_b, min_a, min_b;
    logic               swap;
    logic [COORD_W-1:0] maj0, maj1, min0, min1;
    logic [COORD_W-1:0] dmaj, dmin_mag;
    logic               dmin_neg;
    logic [ACC_W-1:0]   round_add;
    logic [ACC_W-1:0]   dividend;

    // step path
    logic               cmd_fire;
    logic               out_free;
    logic               step;
    logic [COORD_W-1:0] minor;
    logic [COORD_W-1:0] px, py;
    logic [COORD_W+PITCH_W-1:0] row_base;
    logic [ADDR_W-1:0]  addr;

    function automatic logic [COORD_W-1:0] clamp(input logic [COORD_W-1:0] v);
        return ({1'b0, v} >= TILE_LIM) ? COORD_MAX : v;
    endfunction

    assign cmd_fire = cmd.valid && cmd.ready;
    assign cmd.ready = (state_reg == S_IDLE);

    // endpoint ordering and slope dividend
    always_comb
    begin
        cx1 = clamp(cmd.start_x);
        cy1 = clamp(cmd.start_y);
        cx2 = clamp(cmd.end_x);
        cy2 = clamp(cmd.end_y);
        adx = (cx2 > cx1) ? cx2 - cx1 : cx1 - cx2;
        ady = (cy2 > cy1) ? cy2 - cy1 : cy1 - cy2;
        // diagonals and points go y-major
        x_major = adx > ady;
        maj_a = x_major ? cx1 : cy1;
        maj_b = x_major ? cx2 : cy2;
        min_a = x_major ? cy1 : cx1;
        min_b = x_major ? cy2 : cx2;
        swap = maj_a > maj_b;
        maj0 = swap ? maj_b : maj_a;
        maj1 = swap ? maj_a : maj_b;
        min0 = swap ? min_b : min_a;
        min1 = swap ? min_a : min_b;
        dmaj = maj1 - maj0;
        dmin_neg = min1 < min0;
        dmin_mag = dmin_neg ? min0 - min1 : min1 - min0;
        // rising slopes round up (ceil), falling slopes truncate then negate
        round_add = dmin_neg ? '0 : ACC_W'(dmaj) - ACC_W'(1);
        dividend = {dmin_mag, {FRAC_W{1'b0}}} + round_add;
    end

    assign div_req.start    = div_start_reg;
    assign div_req.dividend = div_dividend_reg;
    assign div_req.divisor  = div_divisor_reg;

    dda_lr_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // pixel generation: minor coordinate is the integer part of the accumulator
    assign out_free = !out_valid_reg || pix.ready;
    assign step     = (state_reg == S_WALK) && out_free;

    always_comb
    begin
        minor    = acc_reg[ACC_W-1:FRAC_W];
        px       = x_major_reg ? maj_reg : minor;
        py       = x_major_reg ? minor : maj_reg;
        row_base = (COORD_W + PITCH_W)'(py) * (COORD_W + PITCH_W)'(row_pitch_reg);
        addr     = ADDR_W'(row_base + (COORD_W + PITCH_W)'(px));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            row_pitch_reg <= PITCH_RESET;
            out_valid_reg <= 1'b0;
            div_start_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                row_pitch_reg <= cfg_write_data;
            end
            div_start_reg <= cmd_fire;
            if (step)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pix.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (cmd_fire)
                    begin
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    if (div_rsp.done)
                    begin
                        state_reg <= S_WALK;
                    end
                end
                S_WALK:
                begin
                    if (step && (maj_reg == maj_end_reg))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (cmd_fire)
        begin
            x_major_reg      <= x_major;
            neg_reg          <= dmin_neg;
            maj_reg          <= maj0;
            maj_end_reg      <= maj1;
            acc_reg          <= {min0, {FRAC_W{1'b0}}};
            color_reg        <= cmd.line_color;
            div_dividend_reg <= dividend;
            div_divisor_reg  <= DEN_W'(dmaj);
        end
        if ((state_reg == S_DIV) && div_rsp.done)
        begin
            // zero-length lines get a meaningless slope, never added before the end
            slope_reg <= neg_reg ? ACC_W'(-div_rsp.quotient) : div_rsp.quotient;
        end
        if (step)
        begin
            out_x_reg     <= px;
            out_y_reg     <= py;
            out_addr_reg  <= addr;
            out_color_reg <= color_reg;
            out_last_reg  <= (maj_reg == maj_end_reg);
            maj_reg       <= maj_reg + COORD_W'(1);
            acc_reg       <= acc_reg + slope_reg;
        end
    end

    assign pix.valid         = out_valid_reg;
    assign pix.pixel_x       = out_x_reg;
    assign pix.pixel_y       = out_y_reg;
    assign pix.pixel_address = out_addr_reg;
    assign pix.pixel_color   = out_color_reg;
    assign pix.last_pixel    = out_last_reg;

endmodule

/* rtl/core/dda_lr_div.sv */
module dda_lr_div (
    input  logic                clk,
    input  logic                rst_n,
    input  dda_lr_pkg::div_req_t req,
    output dda_lr_pkg::div_rsp_t rsp
);
    import dda_lr_pkg::*;

    localparam int CNT_W = $clog2(ACC_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(ACC_W - 1);

    logic [DEN_W-1:0] rem_reg,  rem_next;
    logic [ACC_W-1:0] quo_reg,  quo_next;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [DEN_W:0]   trial;
    logic             fits;

    // one restoring step per cycle, dividend bits shift out of quo as quotient bits shift in
    always_comb
    begin
        trial    = {rem_reg, quo_reg[ACC_W-1]};
        fits     = trial >= {1'b0, den_reg};
        rem_next = fits ? DEN_W'(trial - {1'b0, den_reg}) : DEN_W'(trial);
        quo_next = {quo_reg[ACC_W-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == LAST_STEP)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= '0;
            quo_reg <= req.dividend;
            den_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule
